// ===== src/aide_pkg.sv =====
package aide_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_NOKEY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [5:0]         hit_position;
    logic [5:0]         fill_count;
  } res_t;

endpackage

// ===== src/aide_if.sv =====
interface aide_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic [5:0]         position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink (input valid, input kind, input value, input position, output ready);
endinterface

interface aide_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [5:0]         hit_position;
  logic [5:0]         fill_count;

  modport source (output valid, output status, output read_value, output hit_position,
                  output fill_count, input ready);
  modport sink (input valid, input status, input read_value, input hit_position,
                input fill_count, output ready);
endinterface

// ===== src/array_insert_delete_engine.sv =====
// Channel | Dir | Fields                                           | Transfer
// in_i    | in  | kind, value, position                            | valid && ready
// out_o   | out | status, read_value, hit_position, fill_count     | valid && ready
//
// Append, rejected items and insert at the end finish from idle; a read waits for RAM data.
// Insert at position p of n entries: entries n down to p move up, one RAM read and write
// per step, then the value goes to p. Delete: scan, then shift, up to the end of the array.
// Reset clears the fill count, sequencer state and output valid, not the entry RAM.
// A stalled output holds one result in the output register and one pending in the sequencer.
module array_insert_delete_engine #(
  parameter int DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aide_in_if.sink     in_i,
  aide_out_if.source  out_o
);

  localparam int AW = $clog2(DEPTH);

  logic           res_valid, res_ready;
  aide_pkg::res_t res, out_q;
  logic           out_valid_q;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata, ram_rdata;

  aide_seq #(.DEPTH(DEPTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  aide_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.read_value   = out_q.read_value;
  assign out_o.hit_position = out_q.hit_position;
  assign out_o.fill_count   = out_q.fill_count;

endmodule

// ===== src/aide_ram.sv =====
module aide_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/aide_seq.sv =====
module aide_seq #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  aide_in_if.sink                  in_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output aide_pkg::res_t           res_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [31:0]              ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [31:0]              ram_rdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDW    = 7'b0000010,
    S_INS    = 7'b0000100,
    S_INSFIN = 7'b0001000,
    S_DSCAN  = 7'b0010000,
    S_DSHIFT = 7'b0100000,
    S_WAIT   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      k_q, k_d;
  logic [AW-1:0]      pm1_q, pm1_d;
  logic [31:0]        val_q, val_d;
  logic [5:0]         hit_q, hit_d;
  aide_pkg::res_t     hold_q, hold_d;
  aide_pkg::res_t     fin_res;
  logic               fin;
  logic               acc;
  logic [PW-1:0]      pos_ext, cnt_ext;
  logic [AW-1:0]      pos_m1;
  logic               k_last;
  logic               full;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign pos_ext    = PW'(in_i.position);
  assign cnt_ext    = PW'(count_q);
  assign pos_m1     = AW'(pos_ext - PW'(1));
  assign k_last     = ((CW'(k_q) + CW'(1)) == count_q);
  assign full       = (count_q >= CW'(DEPTH));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    pm1_d       = pm1_q;
    val_d       = val_q;
    hit_d       = hit_q;
    hold_d      = hold_q;
    fin         = 1'b0;
    fin_res     = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          val_d = in_i.value;
          pm1_d = pos_m1;
          unique case (aide_pkg::kind_e'(in_i.kind))
            aide_pkg::KIND_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_res.status = aide_pkg::ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = AW'(count_q);
                ram_wdata_o = in_i.value;
                count_d     = count_q + CW'(1);
              end
            end
            aide_pkg::KIND_INSERT: begin
              if (full) begin
                fin            = 1'b1;
                fin_res.status = aide_pkg::ST_FULL;
              end else if (in_i.position == 6'd0 || pos_ext > cnt_ext + PW'(1)) begin
                fin            = 1'b1;
                fin_res.status = aide_pkg::ST_BADPOS;
              end else if (pos_ext > cnt_ext) begin
                fin         = 1'b1;
                ram_we_o    = 1'b1;
                ram_waddr_o = pos_m1;
                ram_wdata_o = in_i.value;
                count_d     = count_q + CW'(1);
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(count_q - CW'(1));
                k_d         = AW'(count_q - CW'(1));
                state_d     = S_INS;
              end
            end
            aide_pkg::KIND_DELETE: begin
              if (count_q == '0) begin
                fin            = 1'b1;
                fin_res.status = aide_pkg::ST_NOKEY;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                k_d         = '0;
                state_d     = S_DSCAN;
              end
            end
            aide_pkg::KIND_READ: begin
              if (in_i.position == 6'd0 || pos_ext > cnt_ext) begin
                fin            = 1'b1;
                fin_res.status = aide_pkg::ST_BADPOS;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = pos_m1;
                state_d     = S_RDW;
              end
            end
          endcase
        end
      end
      S_RDW: begin
        fin                = 1'b1;
        fin_res.read_value = ram_rdata_i;
      end
      S_INS: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = k_q + AW'(1);
        ram_wdata_o = ram_rdata_i;
        if (k_q == pm1_q) begin
          state_d = S_INSFIN;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = k_q - AW'(1);
          k_d         = k_q - AW'(1);
        end
      end
      S_INSFIN: begin
        fin         = 1'b1;
        ram_we_o    = 1'b1;
        ram_waddr_o = pm1_q;
        ram_wdata_o = val_q;
        count_d     = count_q + CW'(1);
      end
      S_DSCAN: begin
        if (ram_rdata_i == val_q) begin
          if (k_last) begin
            fin                  = 1'b1;
            fin_res.hit_position = 6'(CW'(k_q) + CW'(1));
            count_d              = count_q - CW'(1);
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = k_q + AW'(1);
            k_d         = k_q + AW'(1);
            hit_d       = 6'(CW'(k_q) + CW'(1));
            state_d     = S_DSHIFT;
          end
        end else if (k_last) begin
          fin            = 1'b1;
          fin_res.status = aide_pkg::ST_NOKEY;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = k_q + AW'(1);
          k_d         = k_q + AW'(1);
        end
      end
      S_DSHIFT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = k_q - AW'(1);
        ram_wdata_o = ram_rdata_i;
        if (k_last) begin
          fin                  = 1'b1;
          fin_res.hit_position = hit_q;
          count_d              = count_q - CW'(1);
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = k_q + AW'(1);
          k_d         = k_q + AW'(1);
        end
      end
      S_WAIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    fin_res.fill_count = 6'(count_d);
    if (fin) begin
      hold_d  = fin_res;
      state_d = res_ready_i ? S_IDLE : S_WAIT;
    end
  end

  assign res_valid_o = fin || (state_q == S_WAIT);
  assign res_o       = (state_q == S_WAIT) ? hold_q : fin_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pm1_q  <= pm1_d;
    val_q  <= val_d;
    hit_q  <= hit_d;
    hold_q <= hold_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.kind == aide_pkg::KIND_APPEND && !full |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not grow the array");

  a_shift_down_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DSHIFT |-> k_q != '0)
    else $error("shift down from entry zero");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT && !res_ready_i |=> state_q == S_WAIT && $stable(hold_q))
    else $error("pending result lost");

endmodule

// ===== sim/aide_checker.sv =====
module aide_checker
  import aide_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  aide_in_if   in_mon,
  aide_out_if  out_mon,
  output int   fail_cnt,
  output int   pending_cnt,
  output int   checked_cnt,
  output int   full_cnt,
  output int   removed_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] entries_q [DEPTH];
  int                 fill_n;
  res_t               expected_q [$];

  function automatic res_t apply_array_op(kind_e k, logic signed [31:0] v, logic [5:0] p);
    res_t r;
    int   at;
    int   i;
    r        = '0;
    r.status = ST_OK;
    case (k)
      KIND_APPEND: begin
        if (fill_n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entries_q[fill_n] = v;
          fill_n++;
        end
      end
      KIND_INSERT: begin
        if (fill_n >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p == 0 || int'(p) > fill_n + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = fill_n; i >= int'(p); i--) entries_q[i] = entries_q[i-1];
          entries_q[int'(p)-1] = v;
          fill_n++;
        end
      end
      KIND_DELETE: begin
        at = -1;
        for (i = 0; i < fill_n; i++) begin
          if (entries_q[i] == v) begin
            at = i;
            break;
          end
        end
        if (at < 0) begin
          r.status = ST_NOKEY;
        end else begin
          for (i = at; i + 1 < fill_n; i++) entries_q[i] = entries_q[i+1];
          fill_n--;
          r.hit_position = 6'(at + 1);
        end
      end
      default: begin
        if (p == 0 || int'(p) > fill_n) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = entries_q[int'(p)-1];
        end
      end
    endcase
    r.fill_count = 6'(fill_n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      fill_n      = 0;
      expected_q.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
      checked_cnt = 0;
      full_cnt    = 0;
      removed_cnt = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          checked_cnt++;
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_mon.status);
            fail_cnt++;
          end
          if (out_mon.read_value !== want.read_value) begin
            $error("read_value: expected %0d actual %0d", want.read_value, out_mon.read_value);
            fail_cnt++;
          end
          if (out_mon.hit_position !== want.hit_position) begin
            $error("hit_position: expected %0d actual %0d", want.hit_position,
                   out_mon.hit_position);
            fail_cnt++;
          end
          if (out_mon.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d actual %0d", want.fill_count, out_mon.fill_count);
            fail_cnt++;
          end
          if (want.status == ST_FULL) full_cnt++;
          if (want.hit_position != 0) removed_cnt++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(apply_array_op(kind_e'(in_mon.kind), in_mon.value,
                                            in_mon.position));
      end
      pending_cnt = expected_q.size();
    end
  end

endmodule

// ===== sim/tb_array_insert_delete_engine.sv =====
module tb_array_insert_delete_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import aide_pkg::*;

  localparam int DEPTH      = 32;
  localparam int PHASE_OPS  = 375;
  localparam int EPOCH_OPS  = 40;

  typedef enum int {EP_GROW, EP_SHRINK, EP_MIX} epoch_e;

  logic clk_i;
  logic rst_ni;

  aide_in_if  in_if ();
  aide_out_if out_if ();

  int fail_cnt, pending_cnt, checked_cnt, full_cnt, removed_cnt;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int n_sent = 0;

  array_insert_delete_engine #(.DEPTH(DEPTH)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  aide_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt),
    .full_cnt    (full_cnt),
    .removed_cnt (removed_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("Timeout: %0d results still pending", pending_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_op(kind_e k, logic signed [31:0] v, logic [5:0] p);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.kind     <= k;
    in_if.value    <= v;
    in_if.position <= p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(15) - 8;
    if (r < 70) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [5:0] pick_pos();
    if ($urandom_range(9) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(DEPTH + 1));
  endfunction

  function automatic kind_e pick_kind(epoch_e ep);
    int r;
    r = $urandom_range(99);
    case (ep)
      EP_GROW: begin
        if (r < 55) return KIND_APPEND;
        if (r < 85) return KIND_INSERT;
        if (r < 93) return KIND_READ;
        return KIND_DELETE;
      end
      EP_SHRINK: begin
        if (r < 10) return KIND_APPEND;
        if (r < 20) return KIND_INSERT;
        if (r < 70) return KIND_DELETE;
        return KIND_READ;
      end
      default: begin
        if (r < 25) return KIND_APPEND;
        if (r < 50) return KIND_INSERT;
        if (r < 75) return KIND_DELETE;
        return KIND_READ;
      end
    endcase
  endfunction

  initial begin
    epoch_e ep;
    int     r;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.kind     <= KIND_APPEND;
    in_if.value    <= '0;
    in_if.position <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty array: bad positions and missing key
    send_op(KIND_READ,   32'sd0, 6'd1);
    send_op(KIND_READ,   32'sd0, 6'd0);
    send_op(KIND_DELETE, 32'sd5, 6'd0);
    send_op(KIND_INSERT, 32'sd9, 6'd2);
    send_op(KIND_INSERT, 32'sd9, 6'd0);
    // build min, 5, max, 0, -1, 5
    send_op(KIND_INSERT, 32'h8000_0000, 6'd1);
    send_op(KIND_APPEND, 32'h7fff_ffff, 6'd63);
    send_op(KIND_APPEND, 32'sd0, 6'd0);
    send_op(KIND_INSERT, -32'sd1, 6'd4);
    send_op(KIND_INSERT, 32'sd5, 6'd2);
    send_op(KIND_INSERT, 32'sd7, 6'd7);
    send_op(KIND_INSERT, 32'sd7, 6'd63);
    send_op(KIND_APPEND, 32'sd5, 6'd0);
    send_op(KIND_READ,   32'sd0, 6'd1);
    send_op(KIND_READ,   32'sd0, 6'd6);
    send_op(KIND_READ,   32'sd0, 6'd7);
    send_op(KIND_READ,   32'sd0, 6'd63);
    // duplicate key: lowest match goes
    send_op(KIND_DELETE, 32'sd5, 6'd0);
    send_op(KIND_READ,   32'sd0, 6'd5);
    send_op(KIND_DELETE, 32'sd1234, 6'd0);
    send_op(KIND_DELETE, -32'sd1, 6'd0);
    send_op(KIND_DELETE, 32'h8000_0000, 6'd0);
    send_op(KIND_DELETE, 32'sd5, 6'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
      ep = EP_GROW;
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (n != 0 && n % EPOCH_OPS == 0) begin
          r  = $urandom_range(99);
          ep = (r < 35) ? EP_GROW : (r < 70) ? EP_SHRINK : EP_MIX;
        end
        send_op(pick_kind(ep), pick_value(), pick_pos());
      end
    end
    in_if.valid <= 1'b0;

    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (DEPTH + 8) @(negedge clk_i);

    $display("Sent %0d operations across four handshake phases; %0d results checked.",
             n_sent, checked_cnt);
    $display("Full-array rejections: %0d, entries removed by key: %0d.",
             full_cnt, removed_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
